FILE: sv/assert_macros.svh
// Assertion macros shared by the remap unit RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, with reset masking the check.
`define TPRM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TPRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tprm_pkg.sv
// Package for the tiled panel pixel remap unit: geometry constants, derived
// widths, layout codes and the result payload type. Depends on nothing.
package tprm_pkg;

  localparam int PANEL_WIDTH  = 64;
  localparam int PANEL_HEIGHT = 32;
  localparam int GRID_COLS    = 2;
  localparam int GRID_ROWS    = 2;

  localparam int DISP_W    = PANEL_WIDTH * GRID_COLS;
  localparam int DISP_H    = PANEL_HEIGHT * GRID_ROWS;
  localparam int NUM_TILES = GRID_COLS * GRID_ROWS;

  localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int TILE_W  = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int PW_W    = $clog2(PANEL_WIDTH);
  localparam int PH_W    = $clog2(PANEL_HEIGHT);
  localparam int CHAIN_W = $clog2(NUM_TILES * PANEL_WIDTH);

  localparam int COORD_W  = 16;
  localparam int CHAN_W   = 8;
  localparam int CHAINX_W = 8;
  localparam int PANELY_W = 5;
  localparam int COLOR_W  = 16;

  typedef enum logic [2:0] {
    LAYOUT_LINE_TL  = 3'd0,
    LAYOUT_LINE_TR  = 3'd1,
    LAYOUT_LINE_BL  = 3'd2,
    LAYOUT_SERP_TL  = 3'd3,
    LAYOUT_SERP_TR  = 3'd4
  } layout_t;

  typedef struct packed {
    logic [CHAINX_W-1:0] chain_x;
    logic [PANELY_W-1:0] panel_y;
    logic [COLOR_W-1:0]  color_565;
  } pix_res_t;

endpackage

FILE: sv/tprm_in_if.sv
// Input channel of the remap unit: one pixel write per transfer.
// Depends on tprm_pkg for field widths.
interface tprm_in_if import tprm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [CHAN_W-1:0]         red;
  logic [CHAN_W-1:0]         green;
  logic [CHAN_W-1:0]         blue;

  modport source (output valid, pos_x, pos_y, red, green, blue, input ready);
  modport sink   (input valid, pos_x, pos_y, red, green, blue, output ready);
endinterface

FILE: sv/tprm_out_if.sv
// Result channel of the remap unit: one chain pixel per transfer.
// Depends on tprm_pkg for field widths.
interface tprm_out_if import tprm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAINX_W-1:0] chain_x;
  logic [PANELY_W-1:0] panel_y;
  logic [COLOR_W-1:0]  color_565;

  modport source (output valid, chain_x, panel_y, color_565, input ready);
  modport sink   (input valid, chain_x, panel_y, color_565, output ready);
endinterface

FILE: sv/tiled_panel_pixel_remap_unit.sv
// Top level of the tiled panel pixel remap unit.
// Depends on tprm_pkg, tprm_in_if, tprm_out_if, tprm_map and assert_macros.svh.
//
// Maps one pixel write on a wall of GRID_COLS x GRID_ROWS LED panels to its
// place on the panel chain: chain column, row inside the panel and RGB565
// colour. Writes with a negative coordinate or one past the display edge are
// dropped and give no result. The unit takes one pixel per clock and keeps
// that rate as long as the sink takes results; each pixel passes through
// the input register and then the result register, with the whole mapping
// done in the logic between them. The layout code is written through
// cfg_we/cfg_data; the user must write it only while the unit is idle, as
// the unit does not enforce it. Codes 5 to 7 act as line top-left down.
`include "assert_macros.svh"

module tiled_panel_pixel_remap_unit import tprm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tprm_in_if.sink     in_pix,
  tprm_out_if.source  out_pix,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data
);

  // Layout register
  logic [2:0] mode_r;

  // Input register stage
  logic                      s1_v_r;
  logic signed [COORD_W-1:0] s1_x_r;
  logic signed [COORD_W-1:0] s1_y_r;
  logic [CHAN_W-1:0]         s1_red_r;
  logic [CHAN_W-1:0]         s1_green_r;
  logic [CHAN_W-1:0]         s1_blue_r;

  // Result register stage
  logic     out_v_r;
  pix_res_t out_res_r;

  logic     s1_in_range;
  pix_res_t s1_res;
  logic     out_open;
  logic     s1_open;

  // Result register takes a new value when empty or when its transfer ends.
  assign out_open = !out_v_r || out_pix.ready;
  // Input register moves on whenever the result side is open; dropped
  // pixels simply vanish at that point.
  assign s1_open  = !s1_v_r || out_open;

  assign in_pix.ready = s1_open;

  tprm_map u_map (
    .pos_x    (s1_x_r),
    .pos_y    (s1_y_r),
    .red      (s1_red_r),
    .green    (s1_green_r),
    .blue     (s1_blue_r),
    .mode     (mode_r),
    .in_range (s1_in_range),
    .res      (s1_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= LAYOUT_LINE_TL;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_data;
      if (s1_open) s1_v_r <= in_pix.valid;
      if (out_open) out_v_r <= s1_v_r && s1_in_range;
    end
  end

  // Payload: hold while stalled, load on advance.
  always_ff @(posedge clk) begin
    if (s1_open) begin
      s1_x_r     <= in_pix.pos_x;
      s1_y_r     <= in_pix.pos_y;
      s1_red_r   <= in_pix.red;
      s1_green_r <= in_pix.green;
      s1_blue_r  <= in_pix.blue;
    end
    if (out_open) out_res_r <= s1_res;
  end

  assign out_pix.valid     = out_v_r;
  assign out_pix.chain_x   = out_res_r.chain_x;
  assign out_pix.panel_y   = out_res_r.panel_y;
  assign out_pix.color_565 = out_res_r.color_565;

  `TPRM_ASSERT(a_drop_gives_nothing, clk, rst_n, (s1_v_r && !s1_in_range && out_open) |=> !out_v_r, "dropped pixel produced a result")
  `TPRM_ASSERT(a_keep_gives_result, clk, rst_n, (s1_v_r && s1_in_range && out_open) |=> out_v_r, "in-range pixel lost")
  `TPRM_ASSERT(a_stall_holds_stage, clk, rst_n, (s1_v_r && !out_open) |=> (s1_v_r && $stable(s1_x_r) && $stable(s1_y_r)), "input stage changed while stalled")
  `TPRM_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!s1_v_r && !out_v_r), "pipeline not empty after reset")

endmodule

FILE: sv/tprm_map.sv
// Combinational pixel mapper: range check, tile lookup, chain column and
// RGB565 packing. Depends on tprm_pkg.
module tprm_map import tprm_pkg::*; (
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [CHAN_W-1:0]         red,
  input  logic [CHAN_W-1:0]         green,
  input  logic [CHAN_W-1:0]         blue,
  input  logic [2:0]                mode,
  output logic                      in_range,
  output pix_res_t                  res
);

  logic [COORD_W-1:0] ux;
  logic [COORD_W-1:0] uy;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col_flip;
  logic [ROW_W-1:0]   row_flip;
  logic [COORD_W-1:0] off_x_full;
  logic [COORD_W-1:0] off_y_full;
  logic [TILE_W-1:0]  base;
  logic [TILE_W-1:0]  tile;
  logic [CHAIN_W-1:0] chain;

  assign ux = pos_x;
  assign uy = pos_y;

  assign in_range = !pos_x[COORD_W-1] && !pos_y[COORD_W-1] &&
                    (ux < COORD_W'(DISP_W)) && (uy < COORD_W'(DISP_H));

  // Independent threshold compares pick the grid column and row.
  always_comb begin
    col = '0;
    for (int k = 1; k < GRID_COLS; k++) begin
      if (ux >= COORD_W'(k * PANEL_WIDTH)) col = COL_W'(k);
    end
  end

  always_comb begin
    row = '0;
    for (int k = 1; k < GRID_ROWS; k++) begin
      if (uy >= COORD_W'(k * PANEL_HEIGHT)) row = ROW_W'(k);
    end
  end

  assign off_x_full = ux - COORD_W'(col) * COORD_W'(PANEL_WIDTH);
  assign off_y_full = uy - COORD_W'(row) * COORD_W'(PANEL_HEIGHT);

  assign col_flip = COL_W'(GRID_COLS - 1) - col;
  assign row_flip = ROW_W'(GRID_ROWS - 1) - row;
  assign base     = TILE_W'(row) * TILE_W'(GRID_COLS);

  always_comb begin
    unique case (layout_t'(mode))
      LAYOUT_LINE_TR: tile = base + TILE_W'(col_flip);
      LAYOUT_LINE_BL: tile = TILE_W'(row_flip) * TILE_W'(GRID_COLS) + TILE_W'(col);
      LAYOUT_SERP_TL: tile = row[0] ? base + TILE_W'(col_flip) : base + TILE_W'(col);
      LAYOUT_SERP_TR: tile = row[0] ? base + TILE_W'(col) : base + TILE_W'(col_flip);
      default:        tile = base + TILE_W'(col);
    endcase
  end

  assign chain = CHAIN_W'(tile) * CHAIN_W'(PANEL_WIDTH) + CHAIN_W'(off_x_full[PW_W-1:0]);

  assign res.chain_x   = CHAINX_W'(chain);
  assign res.panel_y   = PANELY_W'(off_y_full[PH_W-1:0]);
  assign res.color_565 = {red[7:3], green[7:2], blue[7:3]};

endmodule
